// ===== rtl/rswm_pkg.sv =====
`timescale 1ns / 1ps
package rswm_pkg;

    localparam int RSWM_WINDOW = 64;

    typedef struct packed {
        logic        cmd;
        logic [31:0] sample_us;
    } t_in_item;

    typedef struct packed {
        logic [31:0] sample_count;
        logic [31:0] min_us;
        logic [31:0] max_us;
        logic [39:0] mean_q8;
        logic [55:0] variance_int;
        logic [31:0] median_us;
        logic [6:0]  window_fill;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_DIFF, S_DIV, S_STEP, S_ERR, S_MUL, S_ACC, S_VAR,
        S_RING, S_RING2, S_SCAN_RD, S_SCAN_CK, S_UP_RD, S_UP_CK,
        S_DN_RD, S_DN_CK, S_PLACE, S_MED_A, S_MED_B, S_MED_C, S_DONE
    } t_state;

endpackage

// ===== rtl/rswm_if.sv =====
`timescale 1ns / 1ps
interface rswm_in_if import rswm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rswm_out_if import rswm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/running_stats_window_median_top.sv =====
`timescale 1ns / 1ps
// Running timing statistics with a sliding-window median.
// Input channel i_in: cmd (0 = add sample_us, 1 = clear) and sample_us.
// Output channel o_out: one result per input transfer with count, min, max,
// Q32.8 mean, sample variance, window median and window fill.
// One item is handled at a time; i_in.ready is high only while idle.
// A sample passes through a mean update and a window update: one shared
// 64-step restoring divider runs for the mean step and, from two samples on,
// for the variance, one shift-add multiplier runs 40 steps, then a sorted copy of
// the window in RAM is patched: a full window scans for the evicted value
// and moves the hole to where the new sample belongs. The median is the middle
// entry, or the mean of the two middle entries when the fill is even.
// Reset (synchronous, active low) zeroes all statistics; window RAM contents
// are not cleared and are never read before being written.
// A finished result waits in the output register; while the receiver
// stalls, the block holds the next finished result until it is taken.
module running_stats_window_median_top
    import rswm_pkg::*;
#(
    parameter int WINDOW = RSWM_WINDOW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rswm_in_if.sink       i_in,
    rswm_out_if.source    o_out
);
    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW = $clog2(WINDOW + 1);
    localparam logic [FW-1:0] FULL = FW'(WINDOW);
    localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

    t_state r_state, n_state;

    logic [31:0] r_count, n_count;
    logic [31:0] r_min, n_min;
    logic [31:0] r_max, n_max;
    logic [39:0] r_mean, n_mean;
    logic [63:0] r_sq, n_sq;
    logic [55:0] r_var, n_var;
    logic [31:0] r_median, n_median;
    logic [AW-1:0] r_slot, n_slot;
    logic [FW-1:0] r_fill, n_fill;
    logic [31:0] r_samp, n_samp;
    logic [39:0] r_x, n_x;
    logic        r_dir, n_dir;
    logic [39:0] r_d, n_d;
    logic [63:0] r_dq, n_dq;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_dvs, n_dvs;
    logic        r_phase, n_phase;
    logic [5:0]  r_cnt, n_cnt;
    logic [79:0] r_mcand, n_mcand;
    logic [39:0] r_mplier, n_mplier;
    logic [79:0] r_acc, n_acc;
    logic [31:0] r_old, n_old;
    logic [AW-1:0] r_hole, n_hole;
    logic [AW-1:0] r_scan, n_scan;
    logic [31:0] r_mhi, n_mhi;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_out, n_out;

    logic          ring_we, sort_we;
    logic [AW-1:0] ring_raddr, sort_raddr, sort_waddr;
    logic [31:0]   ring_rdata, sort_rdata, sort_wdata;

    logic [32:0]   rem_sh;
    logic [64:0]   sq_sum;
    logic [FW-1:0] half;
    logic [FW+6:0] fill_ext;
    logic [FW:0]   hole_up;

    rswm_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_slot),
        .i_wdata (r_samp),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    rswm_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_sorted (
        .i_clk   (i_clk),
        .i_we    (sort_we),
        .i_waddr (sort_waddr),
        .i_wdata (sort_wdata),
        .i_raddr (sort_raddr),
        .o_rdata (sort_rdata)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    assign rem_sh   = {r_rem[31:0], r_dq[63]};
    assign sq_sum   = {1'b0, r_sq} + {1'b0, r_acc[79:16]};
    assign half     = r_fill >> 1;
    assign fill_ext = {7'd0, r_fill};
    assign hole_up  = {{(FW + 1 - AW){1'b0}}, r_hole} + (FW + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_mean   <= '0;
            r_sq     <= '0;
            r_var    <= '0;
            r_median <= '0;
            r_slot   <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_min    <= n_min;
            r_max    <= n_max;
            r_mean   <= n_mean;
            r_sq     <= n_sq;
            r_var    <= n_var;
            r_median <= n_median;
            r_slot   <= n_slot;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
        end
        r_samp   <= n_samp;
        r_x      <= n_x;
        r_dir    <= n_dir;
        r_d      <= n_d;
        r_dq     <= n_dq;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_phase  <= n_phase;
        r_cnt    <= n_cnt;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
        r_old    <= n_old;
        r_hole   <= n_hole;
        r_scan   <= n_scan;
        r_mhi    <= n_mhi;
        r_out    <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_min    = r_min;
        n_max    = r_max;
        n_mean   = r_mean;
        n_sq     = r_sq;
        n_var    = r_var;
        n_median = r_median;
        n_slot   = r_slot;
        n_fill   = r_fill;
        n_samp   = r_samp;
        n_x      = r_x;
        n_dir    = r_dir;
        n_d      = r_d;
        n_dq     = r_dq;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        n_old    = r_old;
        n_hole   = r_hole;
        n_scan   = r_scan;
        n_mhi    = r_mhi;
        n_out    = r_out;
        n_ovalid = r_ovalid && !o_out.ready;
        ring_we    = 1'b0;
        ring_raddr = r_slot;
        sort_we    = 1'b0;
        sort_waddr = r_hole;
        sort_wdata = sort_rdata;
        sort_raddr = r_scan;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.data.cmd) begin
                        n_count  = '0;
                        n_min    = '0;
                        n_max    = '0;
                        n_mean   = '0;
                        n_sq     = '0;
                        n_var    = '0;
                        n_median = '0;
                        n_slot   = '0;
                        n_fill   = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_samp = i_in.data.sample_us;
                        n_x    = {i_in.data.sample_us, 8'd0};
                        if (r_count == '0) begin
                            n_min = i_in.data.sample_us;
                            n_max = i_in.data.sample_us;
                        end else begin
                            if (i_in.data.sample_us < r_min) n_min = i_in.data.sample_us;
                            if (i_in.data.sample_us > r_max) n_max = i_in.data.sample_us;
                        end
                        if (r_count != '1) n_count = r_count + 32'd1;
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                n_dir   = (r_x >= r_mean);
                n_d     = (r_x >= r_mean) ? (r_x - r_mean) : (r_mean - r_x);
                n_dq    = {24'd0, n_d};
                n_rem   = '0;
                n_dvs   = r_count;
                n_phase = 1'b0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, r_dvs}) begin
                    n_rem = rem_sh - {1'b0, r_dvs};
                    n_dq  = {r_dq[62:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_dq  = {r_dq[62:0], 1'b0};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    if (!r_phase) begin
                        n_state = S_STEP;
                    end else begin
                        n_var   = (n_dq[63:56] != '0) ? '1 : n_dq[55:0];
                        n_state = S_RING;
                    end
                end
            end
            S_STEP: begin
                n_mean  = r_dir ? (r_mean + r_dq[39:0]) : (r_mean - r_dq[39:0]);
                n_state = S_ERR;
            end
            S_ERR: begin
                n_mcand  = {40'd0, (r_dir ? (r_x - r_mean) : (r_mean - r_x))};
                n_mplier = r_d;
                n_acc    = '0;
                n_cnt    = '0;
                n_state  = S_MUL;
            end
            S_MUL: begin
                if (r_mplier[0]) n_acc = r_acc + r_mcand;
                n_mcand  = {r_mcand[78:0], 1'b0};
                n_mplier = {1'b0, r_mplier[39:1]};
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == 6'd39) n_state = S_ACC;
            end
            S_ACC: begin
                n_sq    = sq_sum[64] ? '1 : sq_sum[63:0];
                n_state = S_VAR;
            end
            S_VAR: begin
                if (r_count >= 32'd2) begin
                    n_dq    = r_sq;
                    n_rem   = '0;
                    n_dvs   = r_count - 32'd1;
                    n_phase = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_var   = '0;
                    n_state = S_RING;
                end
            end
            S_RING: begin
                ring_raddr = r_slot;
                n_state    = S_RING2;
            end
            S_RING2: begin
                n_old   = ring_rdata;
                ring_we = 1'b1;
                n_slot  = (r_slot == LAST) ? '0 : r_slot + AW'(1);
                if (r_fill == FULL) begin
                    n_scan  = '0;
                    n_state = S_SCAN_RD;
                end else begin
                    n_hole  = AW'(r_fill);
                    n_fill  = r_fill + FW'(1);
                    n_state = S_UP_RD;
                end
            end
            S_SCAN_RD: begin
                sort_raddr = r_scan;
                n_state    = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (sort_rdata == r_old) begin
                    n_hole  = r_scan;
                    n_state = S_UP_RD;
                end else begin
                    n_scan  = r_scan + AW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_UP_RD: begin
                sort_raddr = AW'(hole_up);
                if (hole_up < {1'b0, r_fill}) n_state = S_UP_CK;
                else n_state = S_DN_RD;
            end
            S_UP_CK: begin
                if (sort_rdata < r_samp) begin
                    sort_we = 1'b1;
                    n_hole  = r_hole + AW'(1);
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_DN_RD: begin
                sort_raddr = r_hole - AW'(1);
                if (r_hole != '0) n_state = S_DN_CK;
                else n_state = S_PLACE;
            end
            S_DN_CK: begin
                if (sort_rdata > r_samp) begin
                    sort_we = 1'b1;
                    n_hole  = r_hole - AW'(1);
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                sort_we    = 1'b1;
                sort_wdata = r_samp;
                n_state    = S_MED_A;
            end
            S_MED_A: begin
                sort_raddr = AW'(half);
                n_state    = S_MED_B;
            end
            S_MED_B: begin
                sort_raddr = AW'(half - FW'(1));
                n_mhi      = sort_rdata;
                if (r_fill[0]) begin
                    n_median = sort_rdata;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_MED_C;
                end
            end
            S_MED_C: begin
                n_median = 32'(({1'b0, r_mhi} + {1'b0, sort_rdata}) >> 1);
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_out.sample_count = r_count;
                    n_out.min_us       = r_min;
                    n_out.max_us       = r_max;
                    n_out.mean_q8      = r_mean;
                    n_out.variance_int = r_var;
                    n_out.median_us    = r_median;
                    n_out.window_fill  = fill_ext[6:0];
                    n_ovalid           = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/rswm_ram.sv =====
`timescale 1ns / 1ps
module rswm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
